// ----- rtl/core/isst_pkg.sv -----
// Shared types and constants for the interval sample statistics block.
// Holds the word layouts of the input and result channels and of the front-to-back queue.
// No dependencies.
package isst_pkg;

  localparam int unsigned TimeBits = 48;
  localparam int unsigned SampleW  = 32;
  localparam int unsigned CountW   = 32;
  localparam int unsigned SumW     = 64;
  localparam int unsigned LenW     = 32;

  localparam logic [LenW-1:0]   LenReset = 32'd1000000;
  localparam logic [CountW-1:0] CountMax = '1;
  localparam logic [SumW-1:0]   SumMax   = {1'b0, {(SumW-1){1'b1}}};
  localparam logic [SumW-1:0]   SumMin   = {1'b1, {(SumW-1){1'b0}}};

  typedef enum logic {
    OP_RECORD = 1'b0,
    OP_READ   = 1'b1
  } isst_op_e;

  typedef struct packed {
    isst_op_e                   op;
    logic [TimeBits-1:0]        now;
    logic signed [SampleW-1:0]  value;
  } isst_in_t;

  typedef struct packed {
    logic [CountW-1:0]          count;
    logic signed [SumW-1:0]     sum;
    logic signed [SampleW-1:0]  min_value;
    logic signed [SampleW-1:0]  max_value;
    logic                       has_samples;
  } isst_out_t;

  // Classified word: interval number already worked out by the front.
  typedef struct packed {
    isst_op_e                   op;
    logic [TimeBits-1:0]        iv;
    logic signed [SampleW-1:0]  sample;
  } isst_cls_t;

endpackage

// ----- rtl/core/isst_fifo.sv -----
// Two-entry word queue used between front and back and on the result side.
// Generic over the word width; no package dependency.
module isst_fifo #(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ----- rtl/core/isst_front.sv -----
// Front end: accepts an input word, extends the sample and divides the
// timestamp by the interval length, one quotient bit a cycle.
// Depends on isst_pkg.
module isst_front #(
  parameter int unsigned SampleBits = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [isst_pkg::LenW-1:0] len_i,
  input  logic                      push_i,
  input  isst_pkg::isst_in_t        data_i,
  output logic                      full_o,
  output isst_pkg::isst_cls_t       cls_o,
  output logic                      cls_push_o,
  input  logic                      cls_full_i
);

  import isst_pkg::*;

  localparam int unsigned ShAmt = SampleW - SampleBits;
  localparam int unsigned StepW = $clog2(TimeBits);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDiv  = 2'd1;
  localparam logic [1:0] StPush = 2'd2;

  logic [1:0]                state_q, state_d;
  logic [StepW-1:0]          step_q, step_d;
  logic [TimeBits-1:0]       quot_q;
  logic [LenW-1:0]           rem_q;
  logic [LenW-1:0]           div_q;
  isst_op_e                  op_q;
  logic signed [SampleW-1:0] smp_q;

  logic                      accept;
  logic [LenW:0]             trial;
  logic [LenW:0]             diff;
  logic                      ge;
  logic [LenW-1:0]           rem_d;
  logic signed [SampleW-1:0] smp_sh;
  logic signed [SampleW-1:0] smp_ext;

  assign accept = push_i && (state_q == StIdle);
  assign full_o = (state_q != StIdle);

  // Keep only the low SampleBits of the value, sign-extended.
  assign smp_sh  = data_i.value <<< ShAmt;
  assign smp_ext = smp_sh >>> ShAmt;

  // Restoring division step: shift in the next dividend bit, subtract if it fits.
  assign trial = {rem_q, quot_q[TimeBits-1]};
  assign ge    = (trial >= {1'b0, div_q});
  assign diff  = trial - {1'b0, div_q};
  assign rem_d = ge ? diff[LenW-1:0] : trial[LenW-1:0];

  assign cls_o      = '{op: op_q, iv: quot_q, sample: smp_q};
  assign cls_push_o = (state_q == StPush) && !cls_full_i;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      StIdle: begin
        step_d = '0;
        if (accept) begin
          state_d = StDiv;
        end
      end
      StDiv: begin
        step_d = step_q + StepW'(1);
        if (step_q == StepW'(TimeBits - 1)) begin
          state_d = StPush;
        end
      end
      StPush: begin
        if (!cls_full_i) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      quot_q <= data_i.now;
      rem_q  <= '0;
      // a zero length counts as one tick
      div_q  <= (len_i == '0) ? LenW'(1) : len_i;
      op_q   <= data_i.op;
      smp_q  <= smp_ext;
    end else if (state_q == StDiv) begin
      quot_q <= {quot_q[TimeBits-2:0], ge};
      rem_q  <= rem_d;
    end
  end

endmodule

// ----- rtl/core/isst_back.sv -----
// Back end: rolls the interval slots, folds samples into the current slot
// and forms the read word from the last complete interval.
// Depends on isst_pkg.
module isst_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  isst_pkg::isst_cls_t cls_i,
  input  logic                cls_empty_i,
  output logic                cls_pop_o,
  output isst_pkg::isst_out_t res_o,
  output logic                res_push_o,
  input  logic                res_full_i
);

  import isst_pkg::*;

  logic [TimeBits-1:0]       ivn_q, ivn_nx_q;
  logic [CountW-1:0]         cur_cnt_q, cur_cnt_d, last_cnt_q, last_cnt_d;
  logic signed [SumW-1:0]    cur_sum_q, cur_sum_d, last_sum_q, last_sum_d;
  logic signed [SampleW-1:0] cur_min_q, cur_min_d, last_min_q, last_min_d;
  logic signed [SampleW-1:0] cur_max_q, cur_max_d, last_max_q, last_max_d;

  logic                      is_same, is_next, take;
  logic [CountW-1:0]         b_cnt;
  logic signed [SumW-1:0]    b_sum;
  logic signed [SampleW-1:0] b_min, b_max;
  logic signed [SumW-1:0]    v64, sum_raw;
  logic                      ovf;

  assign is_same = (cls_i.iv == ivn_q);
  assign is_next = (cls_i.iv == ivn_nx_q);

  // Records never stall; reads wait for room on the result side.
  assign take       = !cls_empty_i && ((cls_i.op == OP_RECORD) || !res_full_i);
  assign cls_pop_o  = take;
  assign res_push_o = take && (cls_i.op == OP_READ);

  // Current slot survives only within the same interval.
  assign b_cnt = is_same ? cur_cnt_q : '0;
  assign b_sum = is_same ? cur_sum_q : '0;
  assign b_min = is_same ? cur_min_q : '0;
  assign b_max = is_same ? cur_max_q : '0;

  always_comb begin
    if (is_same) begin
      last_cnt_d = last_cnt_q;
      last_sum_d = last_sum_q;
      last_min_d = last_min_q;
      last_max_d = last_max_q;
    end else if (is_next) begin
      last_cnt_d = cur_cnt_q;
      last_sum_d = cur_sum_q;
      last_min_d = cur_min_q;
      last_max_d = cur_max_q;
    end else begin
      last_cnt_d = '0;
      last_sum_d = '0;
      last_min_d = '0;
      last_max_d = '0;
    end
  end

  assign v64     = SumW'(cls_i.sample);
  assign sum_raw = b_sum + v64;
  assign ovf     = (b_sum[SumW-1] == v64[SumW-1]) && (sum_raw[SumW-1] != b_sum[SumW-1]);

  always_comb begin
    cur_cnt_d = b_cnt;
    cur_sum_d = b_sum;
    cur_min_d = b_min;
    cur_max_d = b_max;
    if (cls_i.op == OP_RECORD) begin
      if (b_cnt == '0) begin
        cur_min_d = cls_i.sample;
        cur_max_d = cls_i.sample;
      end else begin
        cur_min_d = (cls_i.sample < b_min) ? cls_i.sample : b_min;
        cur_max_d = (cls_i.sample > b_max) ? cls_i.sample : b_max;
      end
      cur_cnt_d = (b_cnt == CountMax) ? b_cnt : b_cnt + CountW'(1);
      // clamp to the rail on the side of the sample's sign
      cur_sum_d = ovf ? (v64[SumW-1] ? SumMin : SumMax) : sum_raw;
    end
  end

  always_comb begin
    res_o.count       = last_cnt_d;
    res_o.sum         = last_sum_d;
    res_o.has_samples = (last_cnt_d != '0);
    res_o.min_value   = res_o.has_samples ? last_min_d : '0;
    res_o.max_value   = res_o.has_samples ? last_max_d : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ivn_q      <= '0;
      ivn_nx_q   <= TimeBits'(1);
      cur_cnt_q  <= '0;
      cur_sum_q  <= '0;
      cur_min_q  <= '0;
      cur_max_q  <= '0;
      last_cnt_q <= '0;
      last_sum_q <= '0;
      last_min_q <= '0;
      last_max_q <= '0;
    end else if (take) begin
      ivn_q      <= cls_i.iv;
      ivn_nx_q   <= cls_i.iv + TimeBits'(1);
      cur_cnt_q  <= cur_cnt_d;
      cur_sum_q  <= cur_sum_d;
      cur_min_q  <= cur_min_d;
      cur_max_q  <= cur_max_d;
      last_cnt_q <= last_cnt_d;
      last_sum_q <= last_sum_d;
      last_min_q <= last_min_d;
      last_max_q <= last_max_d;
    end
  end

endmodule

// ----- rtl/core/interval_sample_stats.sv -----
// Top level of the interval sample statistics block.
// Depends on isst_pkg, isst_front, isst_fifo and isst_back.
//
// Channel   Direction  Handshake                 Word
// -------   ---------  ------------------------  -------------------------
// input     in         push_i / full_o           data_i   (isst_in_t)
// result    out        empty_o / pop_i           result_o (isst_out_t)
// config    in         cfg_valid_i / cfg_ready_o cfg_data_i (interval length)
//
// The front loads each word, runs it through the bit-serial divider (one
// quotient bit per timestamp bit) and hands it over; it takes no new word
// until the last is handed over. The back folds a word in as it pops it.
// Reset clears all statistics and sets the length to 1000000. A full result
// queue holds a read at the head of the middle queue, and all words behind
// it; the front stalls only once that queue fills.
module interval_sample_stats #(
  parameter int unsigned SAMPLE_BITS = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  isst_pkg::isst_in_t        data_i,
  output logic                      full_o,
  output logic                      empty_o,
  input  logic                      pop_i,
  output isst_pkg::isst_out_t       result_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [isst_pkg::LenW-1:0] cfg_data_i
);

  import isst_pkg::*;

  logic [LenW-1:0]               len_q;
  isst_cls_t                     cls_in, cls_out;
  logic                          mid_push, mid_full, mid_empty, mid_pop;
  logic [$bits(isst_cls_t)-1:0]  mid_data;
  isst_out_t                     res_word;
  logic                          res_push, res_full;
  logic [$bits(isst_out_t)-1:0]  res_data;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= LenReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      len_q <= cfg_data_i;
    end
  end

  isst_front #(
    .SampleBits (SAMPLE_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .len_i      (len_q),
    .push_i     (push_i),
    .data_i     (data_i),
    .full_o     (full_o),
    .cls_o      (cls_in),
    .cls_push_o (mid_push),
    .cls_full_i (mid_full)
  );

  isst_fifo #(
    .Width ($bits(isst_cls_t))
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .data_i  (cls_in),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .data_o  (mid_data),
    .empty_o (mid_empty)
  );

  assign cls_out = isst_cls_t'(mid_data);

  isst_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cls_i       (cls_out),
    .cls_empty_i (mid_empty),
    .cls_pop_o   (mid_pop),
    .res_o       (res_word),
    .res_push_o  (res_push),
    .res_full_i  (res_full)
  );

  isst_fifo #(
    .Width ($bits(isst_out_t))
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_word),
    .full_o  (res_full),
    .pop_i   (pop_i),
    .data_o  (res_data),
    .empty_o (empty_o)
  );

  assign result_o = isst_out_t'(res_data);

  // Neither queue may be pushed while full: a word would be dropped.
  a_mid_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_push |-> !mid_full)
    else $error("middle queue pushed while full");

  a_res_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> !res_full)
    else $error("result queue pushed while full");

  // An accepted word keeps the front busy for the divide.
  a_front_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !full_o) |=> full_o)
    else $error("front free right after accepting a word");

  a_has_samples: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o |-> (result_o.has_samples == (result_o.count != '0)))
    else $error("has_samples disagrees with count");

endmodule

// ----- verif/interval_sample_stats_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for interval_sample_stats: follows the three channels and keeps its own
// copy of the interval statistics. Checks every popped result word field by field.
// Depends on isst_pkg.
module interval_sample_stats_checker
  import isst_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic              full_i,
  input  isst_in_t          data_i,
  input  logic              pop_i,
  input  logic              empty_i,
  input  isst_out_t         result_i,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [LenW-1:0]   cfg_data_i,
  output int unsigned       mismatches_o,
  output int unsigned       reads_owed_o
);

  localparam int unsigned PrintCap = 200;

  logic [LenW-1:0]            ticks_per_iv;
  logic [TimeBits-1:0]        iv_now;
  logic [CountW-1:0]          cur_cnt, last_cnt;
  logic signed [SumW-1:0]     cur_sum, last_sum;
  logic signed [SampleW-1:0]  cur_min, cur_max, last_min, last_max;
  isst_out_t                  summaries_owed[$];

  task automatic report(input string what);
    if (mismatches_o < PrintCap) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
    mismatches_o++;
  endtask

  task automatic clear_current();
    cur_cnt = '0;
    cur_sum = '0;
    cur_min = '0;
    cur_max = '0;
  endtask

  task automatic clear_last();
    last_cnt = '0;
    last_sum = '0;
    last_min = '0;
    last_max = '0;
  endtask

  // Move to the interval of this timestamp: roll on one ahead, clear on any other jump.
  task automatic roll_to(input logic [TimeBits-1:0] stamp);
    logic [TimeBits-1:0] divisor, iv, next_iv;
    divisor = (ticks_per_iv == '0) ? TimeBits'(1) : TimeBits'(ticks_per_iv);
    iv      = stamp / divisor;
    next_iv = iv_now + TimeBits'(1);
    if (iv != iv_now) begin
      if (iv == next_iv) begin
        last_cnt = cur_cnt;
        last_sum = cur_sum;
        last_min = cur_min;
        last_max = cur_max;
        clear_current();
      end else begin
        clear_current();
        clear_last();
      end
      iv_now = iv;
    end
  endtask

  task automatic take_sample(input logic [SampleW-1:0] raw);
    logic signed [SampleW-1:0] smp;
    logic signed [SumW:0]      wide;
    // keep the low SAMPLE_BITS bits, sign-extended
    smp = $signed(raw << (SampleW - SAMPLE_BITS)) >>> (SampleW - SAMPLE_BITS);
    if (cur_cnt == '0) begin
      cur_min = smp;
      cur_max = smp;
    end else begin
      if (smp < cur_min) cur_min = smp;
      if (smp > cur_max) cur_max = smp;
    end
    if (cur_cnt != CountMax) cur_cnt++;
    wide = $signed({cur_sum[SumW-1], cur_sum}) + (SumW+1)'(smp);
    if (wide[SumW] != wide[SumW-1]) begin
      cur_sum = wide[SumW] ? SumMin : SumMax;
    end else begin
      cur_sum = wide[SumW-1:0];
    end
  endtask

  function automatic isst_out_t last_summary();
    isst_out_t w;
    w.count       = last_cnt;
    w.sum         = last_sum;
    w.min_value   = (last_cnt != '0) ? last_min : '0;
    w.max_value   = (last_cnt != '0) ? last_max : '0;
    w.has_samples = (last_cnt != '0);
    return w;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    isst_out_t want;
    if (!rst_ni) begin
      ticks_per_iv = LenReset;
      iv_now       = '0;
      clear_current();
      clear_last();
      summaries_owed.delete();
      mismatches_o = 0;
      reads_owed_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) ticks_per_iv = cfg_data_i;
      if (push_i && !full_i) begin
        roll_to(data_i.now);
        if (data_i.op == OP_RECORD) begin
          take_sample(data_i.value);
        end else begin
          summaries_owed.insert(summaries_owed.size(), last_summary());
        end
      end
      if (pop_i && !empty_i) begin
        if (summaries_owed.size() == 0) begin
          report("result word with no read waiting");
        end else begin
          want = summaries_owed.pop_front();
          if (result_i.count != want.count)
            report($sformatf("count got %0d want %0d", result_i.count, want.count));
          if (result_i.sum != want.sum)
            report($sformatf("sum got %0d want %0d", result_i.sum, want.sum));
          if (result_i.min_value != want.min_value)
            report($sformatf("min got %0d want %0d", result_i.min_value, want.min_value));
          if (result_i.max_value != want.max_value)
            report($sformatf("max got %0d want %0d", result_i.max_value, want.max_value));
          if (result_i.has_samples != want.has_samples)
            report($sformatf("has_samples got %0b want %0b", result_i.has_samples,
                             want.has_samples));
        end
      end
      reads_owed_o = summaries_owed.size();
    end
  end

endmodule

// ----- verif/interval_sample_stats_tb.sv -----
`timescale 1ns / 1ps
// Top of the interval_sample_stats testbench: clock, reset, stimulus and verdict.
// Depends on isst_pkg, interval_sample_stats and interval_sample_stats_checker.
module interval_sample_stats_tb;
  import isst_pkg::*;

  localparam int unsigned SampleBits  = 32;
  localparam int unsigned DrainCycles = 200;
  localparam int unsigned CycleLimit  = 500000;
  localparam int unsigned PhaseWords  = 175;

  logic                clk_i;
  logic                rst_ni;
  logic                push_i;
  isst_in_t            data_i;
  logic                full_o;
  logic                empty_o;
  logic                pop_i;
  isst_out_t           result_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [LenW-1:0]     cfg_data_i;
  int unsigned         mismatches;
  int unsigned         reads_owed;
  int unsigned         cycles = 0;
  logic                calm;

  interval_sample_stats #(.SAMPLE_BITS(SampleBits)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_i),
    .data_i      (data_i),
    .full_o      (full_o),
    .empty_o     (empty_o),
    .pop_i       (pop_i),
    .result_o    (result_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  interval_sample_stats_checker #(.SAMPLE_BITS(SampleBits)) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push_i),
    .full_i       (full_o),
    .data_i       (data_i),
    .pop_i        (pop_i),
    .empty_i      (empty_o),
    .result_i     (result_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .mismatches_o (mismatches),
    .reads_owed_o (reads_owed)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic int unsigned pause_len();
    return calm ? 0 : $urandom_range(0, 4);
  endfunction

  // Tasks start and end just after a falling edge; push stays high across back-to-back words.
  task automatic offer_word(input isst_op_e op, input logic [TimeBits-1:0] stamp,
                            input logic [SampleW-1:0] smp);
    int unsigned idle;
    idle = pause_len();
    if (idle != 0) begin
      push_i = 1'b0;
      repeat (idle) @(negedge clk_i);
    end
    push_i       = 1'b1;
    data_i.op    = op;
    data_i.now   = stamp;
    data_i.value = smp;
    do @(posedge clk_i); while (full_o);
    @(negedge clk_i);
  endtask

  // Drain every read, let stray records clear the front, then write the length.
  task automatic write_length(input logic [LenW-1:0] len);
    push_i = 1'b0;
    while (reads_owed != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i  = len;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic logic [SampleW-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return '0;
      3:       return '1;
      default: return $urandom();
    endcase
  endfunction

  initial begin
    pop_i = 1'b0;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      int unsigned idle;
      idle = pause_len();
      if (idle != 0) begin
        pop_i = 1'b0;
        repeat (idle) @(negedge clk_i);
      end
      pop_i = 1'b1;
      do @(posedge clk_i); while (empty_o);
      @(negedge clk_i);
    end
  end

  initial begin
    logic [LenW-1:0]     lengths[8];
    logic [TimeBits-1:0] tick, span;
    isst_op_e            op;
    int unsigned         r;

    rst_ni      = 1'b0;
    push_i      = 1'b0;
    data_i      = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    calm        = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // reset length: empty read, extremes, roll, jump, time going backwards
    offer_word(OP_READ,   48'd0,         32'h0);
    offer_word(OP_RECORD, 48'd5,         32'h7FFF_FFFF);
    offer_word(OP_RECORD, 48'd10,        32'h8000_0000);
    offer_word(OP_RECORD, 48'd999_999,   32'h0001_8000);
    offer_word(OP_READ,   48'd999_999,   32'h0);
    offer_word(OP_RECORD, 48'd1_000_000, 32'hFFFF_FFFF);
    offer_word(OP_READ,   48'd1_500_000, 32'h0);
    offer_word(OP_RECORD, 48'd3_000_000, 32'h0);
    offer_word(OP_READ,   48'd3_000_001, 32'h0);
    offer_word(OP_RECORD, 48'd3_000_002, 32'h1234);
    offer_word(OP_RECORD, 48'd500,       32'd7);
    offer_word(OP_READ,   48'd1_000_000, 32'h0);
    offer_word(OP_READ,   '1,            32'hFFFF_FFFF);

    // one-tick intervals: interval number wraps at the top of the timestamp range
    write_length(32'd1);
    offer_word(OP_RECORD, 48'hFFFF_FFFF_FFFE, 32'd3);
    offer_word(OP_READ,   48'hFFFF_FFFF_FFFF, 32'h0);
    offer_word(OP_RECORD, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFB);
    offer_word(OP_READ,   48'd0,              32'h0);

    // zero length behaves as one tick
    write_length(32'd0);
    offer_word(OP_RECORD, 48'd40, 32'd9);
    offer_word(OP_READ,   48'd41, 32'h0);

    write_length(32'hFFFF_FFFF);
    offer_word(OP_RECORD, 48'd0,           32'hFFFF_FFFD);
    offer_word(OP_RECORD, 48'hFFFF_FFFE,   32'd4);
    offer_word(OP_READ,   48'hFFFF_FFFF,   32'h0);

    lengths = '{32'd1, 32'd7, 32'd1000, LenReset, 32'hFFFF_FFFF, 32'd0,
                LenW'($urandom_range(2, 65535)), LenW'($urandom_range(1, 32'hFFFF_FFFF))};
    foreach (lengths[p]) begin
      write_length(lengths[p]);
      calm = (p % 3 == 2);
      span = (lengths[p] == '0) ? TimeBits'(1) : TimeBits'(lengths[p]);
      tick = TimeBits'({$urandom(), $urandom()});
      repeat (PhaseWords) begin
        // mostly walk forward within or into the next interval, now and then jump about
        r = $urandom_range(0, 99);
        if (r < 60)      tick = tick + TimeBits'($urandom_range(0, 32'(span / 3)));
        else if (r < 85) tick = tick + span;
        else if (r < 93) tick = tick + span * TimeBits'($urandom_range(2, 5));
        else if (r < 97) tick = tick - span * TimeBits'($urandom_range(1, 3));
        else             tick = TimeBits'({$urandom(), $urandom()});
        op = ($urandom_range(0, 99) < 30) ? OP_READ : OP_RECORD;
        offer_word(op, tick, pick_sample());
      end
    end

    push_i = 1'b0;
    calm   = 1'b0;
    while (reads_owed != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
